[src/lpr_pkg.sv]
// Shared types, constants and helpers for the LRU page replacement block.
// No dependencies; every other file in src except lpr_req_if refers to this package by scoped name.
package lpr_pkg;

	// Default sizing of the frame table.
	localparam int MAX_FRAMES_DEF = 16;
	localparam int PAGE_BITS_DEF  = 8;

	// Configuration register and fault counter widths.
	localparam int          CFG_W        = 5;
	localparam int          FAULT_W      = 16;
	localparam logic [4:0]  FRAMES_RESET = 5'd16;
	localparam logic [15:0] FAULT_MAX    = 16'hFFFF;

	// Bits needed to name one frame out of n frames.
	function automatic int frame_bits(input int n);
		frame_bits = (n > 1) ? $clog2(n) : 1;
	endfunction

	// Sequencer states: wait for a reference, compare, update the chain.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD
	} state_t;

	// Controls broadcast to every cell of the recency chain.
	typedef struct packed {
		logic cmp;        // latch this cell's page compare
		logic upd;        // apply the recency update
		logic shift_all;  // full miss: every cell takes its neighbor
		logic shift_pfx;  // hit: cells at or after the match take their neighbor
	} cell_ctl_t;

	// Per-cell position flags decoded from the fill count.
	typedef struct packed {
		logic active;     // cell holds an occupied entry
		logic tail;       // cell receives the moved or new entry
	} cell_sel_t;

endpackage

[src/lpr_req_if.sv]
// Reference channel: valid/ready handshake with page number and run end flag.
// Depends on nothing but its own parameter.
interface lpr_req_if #(
	parameter int PAGE_BITS = 8
);
	logic                 valid;
	logic                 ready;
	logic [PAGE_BITS-1:0] page;
	logic                 last_reference;

	modport source (output valid, output page, output last_reference, input ready);
	modport sink   (input valid, input page, input last_reference, output ready);
endinterface

[src/lpr_rsp_if.sv]
// Result channel: valid/ready handshake with hit, frame, fault total and run end.
// Uses lpr_pkg::frame_bits to size the frame field.
interface lpr_rsp_if #(
	parameter int MAX_FRAMES = 16
);
	localparam int FRAME_W = lpr_pkg::frame_bits(MAX_FRAMES);

	logic                        valid;
	logic                        ready;
	logic                        hit;
	logic [FRAME_W-1:0]          frame;
	logic [lpr_pkg::FAULT_W-1:0] fault_total;
	logic                        run_end;

	modport source (output valid, output hit, output frame, output fault_total,
		output run_end, input ready);
	modport sink   (input valid, input hit, input frame, input fault_total,
		input run_end, output ready);
endinterface

[src/lpr_cell.sv]
// One cell of the recency chain: holds a frame number and its page, compares the
// page against a reference and shifts toward the LRU end. Depends on lpr_pkg.
module lpr_cell #(
	parameter int PAGE_BITS = lpr_pkg::PAGE_BITS_DEF,
	parameter int FRAME_W   = lpr_pkg::frame_bits(lpr_pkg::MAX_FRAMES_DEF)
) (
	input  logic                  clk,
	input  lpr_pkg::cell_ctl_t    ctl,
	input  lpr_pkg::cell_sel_t    sel,
	input  logic [PAGE_BITS-1:0]  page_in,
	input  logic [FRAME_W-1:0]    mover_id,
	input  logic [FRAME_W-1:0]    nbr_id,
	input  logic [PAGE_BITS-1:0]  nbr_page,
	input  logic                  pfx_in,
	output logic                  pfx_out,
	output logic [FRAME_W-1:0]    id,
	output logic [PAGE_BITS-1:0]  page,
	output logic                  match
);

	logic [FRAME_W-1:0]   id_q;
	logic [PAGE_BITS-1:0] page_q;
	logic                 match_q;
	logic                 shift;

	// The match prefix runs along the chain; a hit shifts every cell from the match on.
	assign pfx_out = pfx_in | match_q;
	assign shift   = ctl.shift_all | (ctl.shift_pfx & pfx_out);

	// Compare while cmp is set, then take the neighbor or the moved entry on upd.
	always_ff @(posedge clk) begin
		if (ctl.cmp) begin
			match_q <= sel.active && (page_q == page_in);
		end
		if (ctl.upd) begin
			if (sel.tail) begin
				id_q   <= mover_id;
				page_q <= page_in;
			end else if (shift) begin
				id_q   <= nbr_id;
				page_q <= nbr_page;
			end
		end
	end

	assign id    = id_q;
	assign page  = page_q;
	assign match = match_q;

endmodule

[src/lru_page_replacement.sv]
// Top level of the LRU page replacement block: sequencer, fill and fault counters,
// result register and the chain of lpr_cell. Depends on lpr_pkg, lpr_req_if, lpr_rsp_if.
//
//   Channel   Direction  Handshake          Payload
//   req       in         valid/ready        page, last_reference
//   rsp       out        valid/ready        hit, frame, fault_total, run_end
//   cfg       in         cfg_wr_en only     cfg_wr_data (frames_in_use)
//
// Each reference passes through three states: the idle state that accepts it, the
// compare state that compares its page in every cell, and the update state that shifts
// the recency chain and loads the result register. A new reference is accepted only
// while the sequencer is idle, so none is taken before the last one has loaded its result.
// The update cycle waits while the result register still holds an untaken result.
// Reset empties the table and clears the fault count at once; there is no clearing pass.
module lru_page_replacement #(
	parameter int MAX_FRAMES = lpr_pkg::MAX_FRAMES_DEF,
	parameter int PAGE_BITS  = lpr_pkg::PAGE_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	lpr_req_if.sink                   req,
	lpr_rsp_if.source                 rsp,
	input  logic                      cfg_wr_en,
	input  logic [lpr_pkg::CFG_W-1:0] cfg_wr_data
);

	localparam int FRAME_W = lpr_pkg::frame_bits(MAX_FRAMES);
	localparam int CNT_W   = $clog2(MAX_FRAMES + 1);

	lpr_pkg::state_t             state_q, state_d;
	logic [lpr_pkg::CFG_W-1:0]   frames_q;
	logic [CNT_W-1:0]            filled_q;
	logic [CNT_W-1:0]            n_act;
	logic [lpr_pkg::FAULT_W-1:0] fault_q, fault_next;
	logic [PAGE_BITS-1:0]        req_page_q;
	logic                        req_last_q;
	logic                        rsp_valid_q;
	logic                        rsp_hit_q;
	logic [FRAME_W-1:0]          rsp_frame_q;
	logic [lpr_pkg::FAULT_W-1:0] rsp_fault_q;
	logic                        rsp_end_q;

	logic                        accept;
	logic                        upd_go;
	logic                        full;
	logic                        hit;
	logic [FRAME_W-1:0]          hit_id;
	logic [FRAME_W-1:0]          mover_id;
	lpr_pkg::cell_ctl_t          cell_ctl;
	logic                        req_ready;

	logic [FRAME_W-1:0]          cell_id   [MAX_FRAMES];
	logic [PAGE_BITS-1:0]        cell_page [MAX_FRAMES];
	logic [MAX_FRAMES-1:0]       cell_match;
	logic [MAX_FRAMES:0]         pfx;

	// Number of frames managed: zero acts as one, large values clip to the table size.
	always_comb begin
		if (frames_q == '0) begin
			n_act = CNT_W'(1);
		end else if (32'(frames_q) > MAX_FRAMES) begin
			n_act = CNT_W'(MAX_FRAMES);
		end else begin
			n_act = CNT_W'(frames_q);
		end
	end

	assign full   = (filled_q == n_act);
	assign accept = req.valid && req_ready;
	assign upd_go = (state_q == lpr_pkg::ST_UPD) && (!rsp_valid_q || rsp.ready);

	// Hit detection and the frame number of the matching cell.
	always_comb begin
		hit_id = '0;
		for (int k = 0; k < MAX_FRAMES; k++) begin
			hit_id = hit_id | (cell_match[k] ? cell_id[k] : '0);
		end
	end
	assign hit = |cell_match;

	// The entry that lands at the MRU end: the hit frame, the LRU victim or a fresh frame.
	always_comb begin
		if (hit) begin
			mover_id = hit_id;
		end else if (full) begin
			mover_id = cell_id[0];
		end else begin
			mover_id = FRAME_W'(filled_q);
		end
	end

	// Saturating fault count including this reference.
	assign fault_next = (!hit && fault_q != lpr_pkg::FAULT_MAX) ? fault_q + 1'b1 : fault_q;

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			lpr_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = lpr_pkg::ST_CMP;
				end
			end
			lpr_pkg::ST_CMP: begin
				state_d = lpr_pkg::ST_UPD;
			end
			lpr_pkg::ST_UPD: begin
				if (upd_go) begin
					state_d = lpr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lpr_pkg::ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		req_ready          = 1'b0;
		cell_ctl.cmp       = 1'b0;
		cell_ctl.upd       = 1'b0;
		cell_ctl.shift_all = !hit && full;
		cell_ctl.shift_pfx = hit;
		case (state_q)
			lpr_pkg::ST_IDLE: begin
				req_ready = 1'b1;
			end
			lpr_pkg::ST_CMP: begin
				cell_ctl.cmp = 1'b1;
			end
			lpr_pkg::ST_UPD: begin
				cell_ctl.upd = upd_go;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	assign req.ready = req_ready;

	// Control registers: state, configuration, fill count, fault count, result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lpr_pkg::ST_IDLE;
			frames_q    <= lpr_pkg::FRAMES_RESET;
			filled_q    <= '0;
			fault_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				frames_q <= cfg_wr_data;
				filled_q <= '0;
				fault_q  <= '0;
			end else if (upd_go) begin
				if (req_last_q) begin
					filled_q <= '0;
					fault_q  <= '0;
				end else begin
					fault_q <= fault_next;
					if (!hit && !full) begin
						filled_q <= filled_q + 1'b1;
					end
				end
			end
			if (upd_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Reference capture and result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_page_q <= req.page;
			req_last_q <= req.last_reference;
		end
		if (upd_go) begin
			rsp_hit_q   <= hit;
			rsp_frame_q <= mover_id;
			rsp_fault_q <= fault_next;
			rsp_end_q   <= req_last_q;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.hit         = rsp_hit_q;
	assign rsp.frame       = rsp_frame_q;
	assign rsp.fault_total = rsp_fault_q;
	assign rsp.run_end     = rsp_end_q;

	// The recency chain, LRU at cell 0; each cell takes its right neighbor on a shift.
	assign pfx[0] = 1'b0;
	for (genvar k = 0; k < MAX_FRAMES; k++) begin : g_cell
		lpr_pkg::cell_sel_t   sel;
		logic [FRAME_W-1:0]   nbr_id;
		logic [PAGE_BITS-1:0] nbr_page;

		assign sel.active = (filled_q > CNT_W'(k));
		assign sel.tail   = (hit || full) ? (filled_q == CNT_W'(k + 1))
		                                  : (filled_q == CNT_W'(k));

		if (k == MAX_FRAMES - 1) begin : g_end
			assign nbr_id   = cell_id[k];
			assign nbr_page = cell_page[k];
		end else begin : g_mid
			assign nbr_id   = cell_id[k + 1];
			assign nbr_page = cell_page[k + 1];
		end

		lpr_cell #(
			.PAGE_BITS (PAGE_BITS),
			.FRAME_W   (FRAME_W)
		) u_cell (
			.clk      (clk),
			.ctl      (cell_ctl),
			.sel      (sel),
			.page_in  (req_page_q),
			.mover_id (mover_id),
			.nbr_id   (nbr_id),
			.nbr_page (nbr_page),
			.pfx_in   (pfx[k]),
			.pfx_out  (pfx[k + 1]),
			.id       (cell_id[k]),
			.page     (cell_page[k]),
			.match    (cell_match[k])
		);
	end

`ifndef SYNTH
	// The table never holds more entries than the frames managed.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		filled_q <= n_act)
		else $error("fill count exceeds active frame count");

	// A page is resident in at most one frame.
	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lpr_pkg::ST_UPD) |-> $onehot0(cell_match))
		else $error("page matched in more than one frame");

	// A result appears only from the update cycle.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == lpr_pkg::ST_UPD))
		else $error("result loaded outside the update cycle");

	// The last reference of a run leaves an empty table and a zero fault count.
	a_run_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_go && req_last_q) |=> (filled_q == '0 && fault_q == '0))
		else $error("run end did not clear the table");
`endif

endmodule

[tb/sv/lru_page_replacement_test.sv]
// Self-checking testbench for lru_page_replacement: a directed script followed by
// random reference runs under varied idling and back-pressure.
// Depends on lpr_pkg, lpr_req_if, lpr_rsp_if and the lru_page_replacement RTL.
module lru_page_replacement_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_FRAMES   = lpr_pkg::MAX_FRAMES_DEF;
	localparam int LIMIT_CYCLES = 1_500_000;
	localparam int SETTLE       = 6;
	localparam int HOLD_CYCLES  = 300;

	// One result as the block reports it.
	typedef struct packed {
		logic        hit;
		logic [3:0]  frame;
		logic [15:0] fault_total;
		logic        run_end;
	} page_result_t;

	typedef enum logic {ROW_CFG, ROW_REF} row_kind_t;

	// One line of the directed script; fixed rows carry their result by hand.
	typedef struct packed {
		row_kind_t    kind;
		logic [4:0]   frames;
		logic [7:0]   page;
		logic         last_ref;
		logic         fixed;
		page_result_t want;
	} row_t;

	localparam int SCRIPT_LEN = 21;
	localparam row_t SCRIPT [SCRIPT_LEN] = '{
		// Default sixteen frames after reset: two misses, two hits, run ends.
		'{ROW_REF, 5'd0, 8'h00, 1'b0, 1'b1, '{1'b0, 4'd0, 16'd1, 1'b0}},
		'{ROW_REF, 5'd0, 8'hFF, 1'b0, 1'b1, '{1'b0, 4'd1, 16'd2, 1'b0}},
		'{ROW_REF, 5'd0, 8'h00, 1'b0, 1'b1, '{1'b1, 4'd0, 16'd2, 1'b0}},
		'{ROW_REF, 5'd0, 8'hFF, 1'b1, 1'b1, '{1'b1, 4'd1, 16'd2, 1'b1}},
		// A frame count of zero behaves as one frame.
		'{ROW_CFG, 5'd0, 8'h00, 1'b0, 1'b0, '0},
		'{ROW_REF, 5'd0, 8'h55, 1'b0, 1'b1, '{1'b0, 4'd0, 16'd1, 1'b0}},
		'{ROW_REF, 5'd0, 8'hAA, 1'b0, 1'b1, '{1'b0, 4'd0, 16'd2, 1'b0}},
		'{ROW_REF, 5'd0, 8'hAA, 1'b0, 1'b1, '{1'b1, 4'd0, 16'd2, 1'b0}},
		'{ROW_REF, 5'd0, 8'h55, 1'b1, 1'b1, '{1'b0, 4'd0, 16'd3, 1'b1}},
		// Two frames: the least recently used one is replaced.
		'{ROW_CFG, 5'd2, 8'h00, 1'b0, 1'b0, '0},
		'{ROW_REF, 5'd0, 8'h01, 1'b0, 1'b1, '{1'b0, 4'd0, 16'd1, 1'b0}},
		'{ROW_REF, 5'd0, 8'h02, 1'b0, 1'b1, '{1'b0, 4'd1, 16'd2, 1'b0}},
		'{ROW_REF, 5'd0, 8'h01, 1'b0, 1'b1, '{1'b1, 4'd0, 16'd2, 1'b0}},
		'{ROW_REF, 5'd0, 8'h03, 1'b0, 1'b1, '{1'b0, 4'd1, 16'd3, 1'b0}},
		'{ROW_REF, 5'd0, 8'h02, 1'b0, 1'b1, '{1'b0, 4'd0, 16'd4, 1'b0}},
		// A write in the middle of a run starts a new one; 31 saturates to sixteen.
		'{ROW_CFG, 5'd31, 8'h00, 1'b0, 1'b0, '0},
		'{ROW_REF, 5'd0, 8'h02, 1'b0, 1'b1, '{1'b0, 4'd0, 16'd1, 1'b0}},
		'{ROW_REF, 5'd0, 8'h80, 1'b0, 1'b0, '0},
		'{ROW_REF, 5'd0, 8'h7F, 1'b0, 1'b0, '0},
		'{ROW_REF, 5'd0, 8'h02, 1'b0, 1'b0, '0},
		'{ROW_REF, 5'd0, 8'h02, 1'b1, 1'b0, '0}
	};

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [4:0] cfg_wr_data;

	lpr_req_if #(.PAGE_BITS(lpr_pkg::PAGE_BITS_DEF)) req_ch ();
	lpr_rsp_if #(.MAX_FRAMES(NUM_FRAMES))            rsp_ch ();

	lru_page_replacement dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always #5 clk = ~clk;

	// Predictor state: frame contents, recency chain (LRU first), run counters.
	logic [7:0]   frame_page [NUM_FRAMES];
	logic [3:0]   recency    [NUM_FRAMES];
	int           filled_count;
	logic [15:0]  fault_count;
	logic [4:0]   frames_reg;
	page_result_t expected_results [$];

	// Run statistics and failure counts.
	int refs_sent;
	int results_seen;
	int hits_predicted;
	int frame_writes;
	int mismatches;
	int cycle_count;

	// Idling control for the sender and the receiver.
	int send_idle_pct;
	int recv_idle_pct;
	int hold_starts;
	int hold_seen;
	int hold_left;

	function automatic int active_frames();
		int n;
		n = frames_reg;
		if (n == 0)
			n = 1;
		if (n > NUM_FRAMES)
			n = NUM_FRAMES;
		return n;
	endfunction

	// Move the chain entry at pos to the most recently used end.
	function automatic void promote(input int pos, input int occ);
		logic [3:0] moved;
		moved = recency[pos];
		for (int k = pos; k + 1 < occ; k++)
			recency[k] = recency[k + 1];
		recency[occ - 1] = moved;
	endfunction

	function automatic page_result_t predict_reference(input logic [7:0] pg, input logic last_ref);
		page_result_t res;
		int n;
		int occ;
		logic promoted;
		n = active_frames();
		occ = (filled_count > n) ? n : filled_count;
		res = '0;
		for (int j = 0; j < occ; j++) begin
			if (!res.hit && frame_page[j] == pg) begin
				res.hit = 1'b1;
				res.frame = 4'(j);
			end
		end
		if (res.hit) begin
			promoted = 1'b0;
			for (int j = 0; j < occ; j++) begin
				if (!promoted && recency[j] == res.frame) begin
					promote(j, occ);
					promoted = 1'b1;
				end
			end
		end else begin
			if (fault_count != lpr_pkg::FAULT_MAX)
				fault_count = fault_count + 16'd1;
			if (occ < n) begin
				res.frame = 4'(occ);
				frame_page[occ] = pg;
				recency[occ] = 4'(occ);
				filled_count = occ + 1;
			end else begin
				res.frame = recency[0];
				frame_page[res.frame] = pg;
				promote(0, occ);
			end
		end
		res.fault_total = fault_count;
		res.run_end = last_ref;
		if (last_ref) begin
			filled_count = 0;
			fault_count = '0;
		end
		return res;
	endfunction

	// Present one reference, hold it until the transfer, then log its expected result.
	task automatic send_reference(input logic [7:0] pg, input logic last_ref,
		input logic fixed, input page_result_t want);
		page_result_t predicted;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.page <= pg;
		req_ch.last_reference <= last_ref;
		do
			@(posedge clk);
		while (!req_ch.ready);
		predicted = predict_reference(pg, last_ref);
		expected_results.push_back(fixed ? want : predicted);
		refs_sent++;
		if (predicted.hit)
			hits_predicted++;
		@(negedge clk);
	endtask

	// Stop offering references until every outstanding result has been taken.
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		do
			@(negedge clk);
		while (expected_results.size() != 0);
	endtask

	// Drain, let the block settle, then write the frame count.
	task automatic write_frames(input logic [4:0] value);
		drain_results();
		repeat (SETTLE) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		frames_reg = value;
		filled_count = 0;
		fault_count = '0;
		frame_writes++;
	endtask

	// Runs of references: mostly drawn from a working set near the frame count,
	// some with uniformly random pages, some left open or cut by stray run ends.
	task automatic run_traffic(input int n_items);
		logic [7:0] work_set [24];
		logic [7:0] pg;
		logic       last_ref;
		int sent;
		int run_len;
		int style;
		int set_size;
		sent = 0;
		while (sent < n_items) begin
			run_len = $urandom_range(1, 40);
			style = $urandom_range(0, 9);
			set_size = active_frames() + $urandom_range(0, 4) - 2;
			if (set_size < 1)
				set_size = 1;
			for (int k = 0; k < set_size; k++)
				work_set[k] = 8'($urandom_range(0, 255));
			for (int k = 0; k < run_len; k++) begin
				if (style <= 6)
					pg = work_set[$urandom_range(0, set_size - 1)];
				else
					pg = 8'($urandom_range(0, 255));
				if (style == 9)
					last_ref = ($urandom_range(0, 19) == 0);
				else
					last_ref = (k == run_len - 1);
				send_reference(pg, last_ref, 1'b0, '0);
				sent++;
			end
		end
	endtask

	// Receiver: random stalls, or a long hold-off when one is requested.
	always @(negedge clk) begin
		if (hold_starts != hold_seen) begin
			hold_seen = hold_starts;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Compare every result transfer with the oldest expected result.
	always @(posedge clk) begin
		page_result_t want;
		page_result_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = '{rsp_ch.hit, rsp_ch.frame, rsp_ch.fault_total, rsp_ch.run_end};
			results_seen++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: hit=%0d frame=%0d faults=%0d end=%0d",
						got.hit, got.frame, got.fault_total, got.run_end);
			end else begin
				want = expected_results.pop_front();
				if (got.hit !== want.hit || got.frame !== want.frame ||
						got.fault_total !== want.fault_total ||
						got.run_end !== want.run_end) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch at result %0d: expected hit=%0d frame=%0d faults=%0d end=%0d",
							results_seen, want.hit, want.frame, want.fault_total,
							want.run_end);
						$display("  got hit=%0d frame=%0d faults=%0d end=%0d",
							got.hit, got.frame, got.fault_total, got.run_end);
					end
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		row_t row;
		logic [4:0] pick;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		req_ch.valid = 1'b0;
		req_ch.page = '0;
		req_ch.last_reference = 1'b0;
		rsp_ch.ready = 1'b0;
		for (int k = 0; k < NUM_FRAMES; k++) begin
			frame_page[k] = '0;
			recency[k] = '0;
		end
		filled_count = 0;
		fault_count = '0;
		frames_reg = lpr_pkg::FRAMES_RESET;
		refs_sent = 0;
		results_seen = 0;
		hits_predicted = 0;
		frame_writes = 0;
		mismatches = 0;
		cycle_count = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_starts = 0;
		hold_seen = 0;
		hold_left = 0;

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed script, light idling on both sides.
		send_idle_pct = 10;
		recv_idle_pct = 10;
		for (int r = 0; r < SCRIPT_LEN; r++) begin
			row = SCRIPT[r];
			if (row.kind == ROW_CFG)
				write_frames(row.frames);
			else
				send_reference(row.page, row.last_ref, row.fixed, row.want);
		end

		// Random runs under three idling mixes, with the frame count swept each time.
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 48 : 0;
			recv_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 16 : 0;
			for (int seg = 0; seg < 6; seg++) begin
				case (seg)
					0: pick = 5'd1;
					1: pick = 5'd16;
					2: pick = 5'd0;
					3: pick = 5'd31;
					default: pick = 5'($urandom_range(0, 31));
				endcase
				write_frames(pick);
				if (phase == 0 && seg == 2)
					hold_starts++;
				if (phase == 1 && seg == 3) begin
					run_traffic(50);
					drain_results();
					run_traffic(45);
				end else begin
					run_traffic(95);
				end
			end
		end

		drain_results();
		repeat (SETTLE * 2) @(negedge clk);

		$display("summary: %0d references sent, %0d results checked, %0d hits predicted",
			refs_sent, results_seen, hits_predicted);
		$display("summary: %0d frame count writes from 0 to 31, %0d mismatches",
			frame_writes, mismatches);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
